/* design/triangle_index_assembler_defines.svh */
// ----------------------------------------------------------------------------
// Triangle index assembler assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_INDEX_ASSEMBLER_DEFINES_SVH
`define TRIANGLE_INDEX_ASSEMBLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TIA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("triangle index assembler: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("triangle index assembler: next-cycle check failed");

`endif

/* design/tia_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle index assembler package
// Types, constants and helper functions shared by the assembler modules.
// ----------------------------------------------------------------------------
package tia_pkg;

    localparam int IDX_W      = 16;
    localparam int CORNER_W   = 15;
    localparam int TOTAL_W    = 21;
    localparam int STATUS_W   = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 21;
    localparam int OUT_DATA_W = 72;

    localparam logic [TOTAL_W-1:0] MAX_OUT_INDICES = 21'd1048576;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_STRIP_MODE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VERTEX_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUT_CAPACITY = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CAPACITY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN   = 2'd3;

    localparam logic [IDX_W-1:0] RESTART_INDEX = 16'hFFFF;

    // Result queue geometry.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One queue entry: an optional triangle followed by an optional status.
    typedef struct packed {
        logic                has_tri;
        logic                has_stat;
        logic [CORNER_W-1:0] corner_a;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_c;
        logic [STATUS_W-1:0] status;
        logic [TOTAL_W-1:0]  total;
    } t_rec;

    function automatic logic f_in_range(input logic [IDX_W-1:0] v,
                                        input logic [IDX_W-1:0] vc);
        return !v[IDX_W-1] && (v < vc);
    endfunction

endpackage

/* design/tia_front.sv */
// ----------------------------------------------------------------------------
// Triangle index assembler front end
// Holds configuration and mesh state, accepts one index per cycle while the
// queue has room and builds the triangle and status record that it causes.
// ----------------------------------------------------------------------------
module tia_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tia_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [tia_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tia_pkg::IDX_W-1:0]    i_index,
    input  logic                         i_last,
    input  logic                         i_q_full,
    output logic                         o_push,
    output tia_pkg::t_rec                o_rec
);
    import tia_pkg::*;

    logic                r_strip_mode;
    logic [IDX_W-1:0]    r_vertex_count;
    logic [TOTAL_W-1:0]  r_out_capacity;

    logic [IDX_W-1:0]    r_older, n_older;
    logic [IDX_W-1:0]    r_newer, n_newer;
    logic [1:0]          r_fill, n_fill;
    logic                r_odd, n_odd;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [STATUS_W-1:0] r_err, n_err;

    logic                w_accept;
    logic                w_tri_req;
    logic                w_tri_ok;
    logic [IDX_W-1:0]    w_ta, w_tb, w_tc;
    logic [1:0]          w_pos;
    logic [TOTAL_W-1:0]  w_cap;
    logic                w_cap_over;
    logic [STATUS_W-1:0] w_status;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_q_full;
    assign w_accept    = i_valid && !i_q_full;

    assign w_cap      = (r_out_capacity > MAX_OUT_INDICES) ? MAX_OUT_INDICES : r_out_capacity;
    assign w_cap_over = ({1'b0, r_total} + (TOTAL_W+1)'(3)) > {1'b0, w_cap};
    assign w_pos      = (r_fill > 2'd2) ? 2'd2 : r_fill;

    always_comb begin
        n_older   = r_older;
        n_newer   = r_newer;
        n_fill    = r_fill;
        n_odd     = r_odd;
        n_total   = r_total;
        n_err     = r_err;
        w_tri_req = 1'b0;
        w_tri_ok  = 1'b0;
        w_ta      = r_older;
        w_tb      = r_newer;
        w_tc      = i_index;

        if (!r_strip_mode) begin
            if (r_err == ST_OK) begin
                case (w_pos)
                    2'd0:    n_older   = i_index;
                    2'd1:    n_newer   = i_index;
                    default: w_tri_req = 1'b1;
                endcase
            end
            // The triple position keeps counting after an error for the length check.
            n_fill = (w_pos == 2'd2) ? 2'd0 : w_pos + 2'd1;
        end else if (r_err == ST_OK) begin
            if (i_index == RESTART_INDEX) begin
                n_older = RESTART_INDEX;
                n_newer = RESTART_INDEX;
                n_fill  = 2'd0;
                n_odd   = 1'b0;
            end else if (!f_in_range(i_index, r_vertex_count)) begin
                n_err = ST_RANGE;
            end else begin
                if (r_fill >= 2'd2) begin
                    w_tri_req = 1'b1;
                    w_ta      = r_odd ? r_newer : r_older;
                    w_tb      = r_odd ? r_older : r_newer;
                end
                n_older = r_newer;
                n_newer = i_index;
                if (r_fill < 2'd2) begin
                    n_fill = r_fill + 2'd1;
                end
                n_odd = !r_odd;
            end
        end

        if (w_tri_req) begin
            if (!f_in_range(w_ta, r_vertex_count) || !f_in_range(w_tb, r_vertex_count)
                    || !f_in_range(w_tc, r_vertex_count)) begin
                n_err = ST_RANGE;
            end else if ((w_ta == w_tb) || (w_tb == w_tc) || (w_tc == w_ta)) begin
                w_tri_ok = 1'b0;
            end else if (w_cap_over) begin
                n_err = ST_CAPACITY;
            end else begin
                w_tri_ok = 1'b1;
                n_total  = r_total + TOTAL_W'(3);
            end
        end

        w_status = n_err;
        if (!r_strip_mode && (n_fill != 2'd0)) begin
            w_status = ST_BAD_LEN;
        end
    end

    assign o_push            = w_accept && (w_tri_ok || i_last);
    assign o_rec.has_tri     = w_tri_ok;
    assign o_rec.has_stat    = i_last;
    assign o_rec.corner_a    = w_ta[CORNER_W-1:0];
    assign o_rec.corner_b    = w_tb[CORNER_W-1:0];
    assign o_rec.corner_c    = w_tc[CORNER_W-1:0];
    assign o_rec.status      = w_status;
    assign o_rec.total       = n_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_mode   <= 1'b0;
            r_vertex_count <= 16'd1;
            r_out_capacity <= 21'd1048576;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_STRIP_MODE:   r_strip_mode   <= i_cfg_data[0];
                CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data[IDX_W-1:0];
                CFG_OUT_CAPACITY: r_out_capacity <= i_cfg_data[TOTAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older <= RESTART_INDEX;
            r_newer <= RESTART_INDEX;
            r_fill  <= 2'd0;
            r_odd   <= 1'b0;
            r_total <= '0;
            r_err   <= ST_OK;
        end else if (w_accept) begin
            if (i_last) begin
                // The status transfer closes the mesh; the next index starts fresh.
                r_older <= RESTART_INDEX;
                r_newer <= RESTART_INDEX;
                r_fill  <= 2'd0;
                r_odd   <= 1'b0;
                r_total <= '0;
                r_err   <= ST_OK;
            end else begin
                r_older <= n_older;
                r_newer <= n_newer;
                r_fill  <= n_fill;
                r_odd   <= n_odd;
                r_total <= n_total;
                r_err   <= n_err;
            end
        end
    end

endmodule

/* design/tia_queue.sv */
// ----------------------------------------------------------------------------
// Triangle index assembler record queue
// Short first-in first-out buffer between the front end and the output side.
// ----------------------------------------------------------------------------
module tia_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tia_pkg::t_rec i_rec,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tia_pkg::t_rec o_rec
);
    import tia_pkg::*;

    t_rec               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_full    = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid   = (r_cnt != '0);
    assign o_rec     = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* design/tia_back.sv */
// ----------------------------------------------------------------------------
// Triangle index assembler output side
// Unpacks each queued record into a triangle transfer, a status transfer or both.
// ----------------------------------------------------------------------------
module tia_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  tia_pkg::t_rec                     i_rec,
    output logic                              o_pop,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [tia_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                              o_m_tuser,
    output logic                              o_m_tlast
);
    import tia_pkg::*;

    // Set once the triangle of a two-result record has been transferred.
    logic r_phase;
    logic w_show_tri;
    logic w_fire;

    assign w_show_tri = i_rec.has_tri && !r_phase;
    assign w_fire     = i_valid && i_m_tready;
    assign o_pop      = w_fire && (!w_show_tri || !i_rec.has_stat);

    assign o_m_tvalid = i_valid;
    assign o_m_tuser  = !w_show_tri;
    assign o_m_tlast  = !w_show_tri;
    assign o_m_tdata  = w_show_tri
        ? {4'd0, i_rec.total, ST_OK, i_rec.corner_c, i_rec.corner_b, i_rec.corner_a}
        : {4'd0, i_rec.total, i_rec.status, {(3*CORNER_W){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else if (o_pop) begin
            r_phase <= 1'b0;
        end else if (w_fire && w_show_tri) begin
            r_phase <= 1'b1;
        end
    end

endmodule

/* design/triangle_index_assembler.sv */
// ----------------------------------------------------------------------------
// Triangle index assembler
// Builds triangles from a list or restartable strip of vertex indices.
//
//   Channel   Direction  Handshake                 Payload
//   s         in         i_s_tvalid / o_s_tready   vertex index, last flag
//   m         out        o_m_tvalid / i_m_tready   corners, status, count
//   cfg       in         i_cfg_valid / o_cfg_ready register index, value
//
// One index is taken per cycle while the four-entry record queue has room.
// An index that closes a triangle and ends the mesh needs two output transfers,
// since the output channel moves one transfer per cycle while i_m_tready is high;
// all others need at most one. Reset clears mesh state, queue pointers and restores
// register defaults. A stalled output fills the queue and then holds o_s_tready low.
// ----------------------------------------------------------------------------
`include "triangle_index_assembler_defines.svh"

module triangle_index_assembler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tia_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [tia_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [15:0] vertex_index
    input  logic [tia_pkg::IDX_W-1:0]          i_s_tdata,
    input  logic                               i_s_tlast,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [14:0] corner_a, [29:15] corner_b, [44:30] corner_c,
    // [46:45] status, [67:47] emitted_indices, [71:68] zero
    output logic [tia_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // [0] kind
    output logic                               o_m_tuser,
    output logic                               o_m_tlast
);
    import tia_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_q_valid;
    t_rec w_front_rec;
    t_rec w_head_rec;

    tia_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_index     (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_rec       (w_front_rec)
    );

    tia_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_front_rec),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_rec   (w_head_rec)
    );

    tia_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_rec      (w_head_rec),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // A record is never pushed into a full queue.
    `TIA_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, w_push, !w_full)
    // Triangle transfers carry an ok status and never end the mesh.
    `TIA_ASSERT_NOW(a_tri_clean, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser,
        (o_m_tdata[46:45] == ST_OK) && !o_m_tlast)
    // Status transfers carry no corners.
    `TIA_ASSERT_NOW(a_stat_no_corners, i_clk, i_rst_n, o_m_tvalid && o_m_tuser,
        o_m_tdata[44:0] == '0)
    // A transferred triangle with a status pending is followed by that status.
    `TIA_ASSERT_NEXT(a_stat_follows, i_clk, i_rst_n,
        o_m_tvalid && i_m_tready && !o_m_tuser && !w_pop, o_m_tvalid && o_m_tuser)

endmodule
